### hdl/scd_pkg.sv
// scd_pkg: shared types, constants and code-geometry functions for the SECDED codec.
// Used by scd_pipe and secded_codec_top; depends on nothing.

package scd_pkg;

  // Code geometry
  localparam int MAX_CODE_BITS = 64;
  localparam int CODE_W        = 64;   // width of data_in / data_out
  localparam int SYN_W         = 6;    // syndrome bits, log2 of CODE_W
  localparam int MLEN_W        = 6;    // msg_len register width
  localparam int CLEN_W        = 7;    // code_length field width
  localparam int OUT_W         = 80;   // out tdata, padded to whole bytes

  // Configuration register map
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;
  localparam logic [CFG_AW-1:0] ADDR_MSG_LEN = 2'd0;
  localparam logic [MLEN_W-1:0] MSG_LEN_RST  = 6'd57;

  // Request kinds
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2
  } status_t;

  // Effective code geometry handed to the datapath
  typedef struct packed {
    logic [MLEN_W-1:0] msg_len;
    logic [CLEN_W-1:0] code_len;
  } scd_cfg_t;

  // n = m + p + 1 with p the least count (at least 1) with 2^p - p >= m + 1
  function automatic int code_len_i(input int m);
    int n;
    n = 0;
    for (int p = 7; p >= 1; p--) begin
      if (((1 << p) - p) >= (m + 1)) n = m + p + 1;
    end
    return n;
  endfunction

  // Largest message length whose code still fits
  function automatic int max_msg_i();
    int r;
    r = 1;
    for (int m = 1; m < 64; m++) begin
      if (code_len_i(m) <= MAX_CODE_BITS) r = m;
    end
    return r;
  endfunction

  localparam int MAX_MSG = max_msg_i();

  // Message positions: from 3 upward, skipping powers of two
  function automatic bit is_data_i(input int i);
    return (i >= 3) && ((i & (i - 1)) != 0);
  endfunction

  // Message bit index carried at a message position
  function automatic int data_idx_i(input int i);
    int c;
    c = 0;
    for (int j = 3; j < i; j++) begin
      if (is_data_i(j)) c++;
    end
    return c;
  endfunction

  // Positions whose index has bit j set
  function automatic logic [CODE_W-1:0] pos_mask_f(input int j);
    logic [CODE_W-1:0] r;
    r = '0;
    for (int i = 0; i < CODE_W; i++) begin
      r[i] = ((i >> j) & 1) != 0;
    end
    return r;
  endfunction

  // Clamp the written length and derive the code length
  function automatic scd_cfg_t cfg_from_len(input logic [MLEN_W-1:0] raw);
    scd_cfg_t c;
    int m;
    m = int'(raw);
    if (m == 0) m = 1;
    if (m > MAX_MSG) m = MAX_MSG;
    c.msg_len  = MLEN_W'(m);
    c.code_len = CLEN_W'(code_len_i(m));
    return c;
  endfunction

endpackage

### hdl/scd_pipe.sv
// scd_pipe: three-stage SECDED datapath (place/mask, syndrome, fix/extract + output).
// Depends on scd_pkg.

module scd_pipe (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scd_pkg::scd_cfg_t              cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [scd_pkg::CODE_W-1:0]     in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scd_pkg::CODE_W-1:0]     out_data,
  output scd_pkg::status_t               out_status,
  output logic [scd_pkg::SYN_W-1:0]      out_pos,
  output logic [scd_pkg::CLEN_W-1:0]     out_len
);

  localparam int W = scd_pkg::CODE_W;
  localparam int S = scd_pkg::SYN_W;

  // Stall chain: a stage moves when the next one is empty or moving
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------- Stage 1: place message bits or mask the code word
  logic [W-1:0] msg_mask, code_mask, msg_in, spread, s1_word;

  assign msg_mask  = ~({W{1'b1}} << cfg.msg_len);
  assign code_mask = ~({W{1'b1}} << cfg.code_len);
  assign msg_in    = in_data & msg_mask;

  for (genvar i = 0; i < W; i++) begin : g_spread
    if (scd_pkg::is_data_i(i)) begin : g_d
      assign spread[i] = msg_in[scd_pkg::data_idx_i(i)];
    end else begin : g_p
      assign spread[i] = 1'b0;
    end
  end

  assign s1_word = (in_cmd == scd_pkg::CMD_DECODE) ? (in_data & code_mask) : spread;

  logic         s1_cmd_r;
  logic [W-1:0] s1_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_cmd_r  <= in_cmd;
      s1_word_r <= s1_word;
    end
  end

  // ---------------- Stage 2: XOR syndrome and overall parity
  logic [S-1:0] syn;

  for (genvar j = 0; j < S; j++) begin : g_syn
    localparam logic [W-1:0] PMASK = scd_pkg::pos_mask_f(j);
    assign syn[j] = ^(s1_word_r & PMASK);
  end

  logic         s2_cmd_r;
  logic [W-1:0] s2_word_r;
  logic [S-1:0] s2_syn_r;
  logic         s2_par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_word_r <= s1_word_r;
      s2_syn_r  <= syn;
      s2_par_r  <= ^s1_word_r;
    end
  end

  // ---------------- Stage 3: parity insert or correct and extract
  logic [W-1:0]      enc_word, fixed, msg_out, res_nxt;
  scd_pkg::status_t  status_nxt;
  logic [S-1:0]      pos_nxt;

  always_comb begin
    enc_word = s2_word_r;
    for (int j = 0; j < S; j++) begin
      enc_word[1 << j] = s2_syn_r[j];
    end
    // overall parity covers the check bits just inserted
    enc_word[0] = s2_par_r ^ (^s2_syn_r);
  end

  always_comb begin
    status_nxt = scd_pkg::ST_OK;
    pos_nxt    = '0;
    fixed      = s2_word_r;
    if (s2_syn_r != '0) begin
      if (!s2_par_r || ({1'b0, s2_syn_r} >= cfg.code_len)) begin
        status_nxt = scd_pkg::ST_DOUBLE;
      end else begin
        status_nxt = scd_pkg::ST_SINGLE;
        pos_nxt    = s2_syn_r;
        fixed      = s2_word_r ^ (W'(1) << s2_syn_r);
      end
    end
  end

  // Positions past the code are masked, so unused message bits come out zero
  for (genvar i = 0; i < W; i++) begin : g_extract
    if (scd_pkg::is_data_i(i)) begin : g_d
      assign msg_out[scd_pkg::data_idx_i(i)] = fixed[i];
    end
  end
  for (genvar k = scd_pkg::data_idx_i(W); k < W; k++) begin : g_zero
    assign msg_out[k] = 1'b0;
  end

  assign res_nxt = (s2_cmd_r == scd_pkg::CMD_DECODE) ? msg_out : enc_word;

  logic [W-1:0]                 out_data_r;
  scd_pkg::status_t             out_status_r;
  logic [S-1:0]                 out_pos_r;
  logic [scd_pkg::CLEN_W-1:0]   out_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      out_data_r   <= res_nxt;
      out_status_r <= (s2_cmd_r == scd_pkg::CMD_DECODE) ? status_nxt : scd_pkg::ST_OK;
      out_pos_r    <= (s2_cmd_r == scd_pkg::CMD_DECODE) ? pos_nxt : '0;
      out_len_r    <= cfg.code_len;
    end
  end

  assign out_valid  = v3_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_pos    = out_pos_r;
  assign out_len    = out_len_r;

endmodule

### hdl/secded_codec_top.sv
// secded_codec_top: extended Hamming SECDED encoder/decoder with APB length register.
// Depends on scd_pkg and scd_pipe.
//
//   channel | direction | contents
//   in_     | request   | tuser[0] cmd; tdata[63:0] data_in
//   out_    | result    | tdata[63:0] data_out, [65:64] status, [71:66] error_position,
//           |           |       [78:72] code_length, [79] zero
//   cfg_    | APB write | msg_len at address 0, bits [5:0]
//
// One request per cycle while the output is not stalled; a request's result passes three
// register stages (place/mask, syndrome tree, correct/extract into the output register)
// before it is valid on out_.
// rst_n is synchronous: pipeline empties, msg_len returns to 57.
// A stalled output holds its result; upstream stages keep filling until full.

module secded_codec_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [scd_pkg::CODE_W-1:0]    in_tdata,   // [63:0] data_in
  input  logic [0:0]                    in_tuser,   // [0] cmd
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [scd_pkg::OUT_W-1:0]     out_tdata,  // data_out, status, error_position,
                                                    // code_length, pad
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [scd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [scd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [scd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  // Length register and derived geometry
  logic [scd_pkg::MLEN_W-1:0] msg_len_r;
  scd_pkg::scd_cfg_t          geo_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == scd_pkg::ADDR_MSG_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= scd_pkg::MSG_LEN_RST;
      geo_r     <= scd_pkg::cfg_from_len(scd_pkg::MSG_LEN_RST);
    end else if (cfg_wr) begin
      msg_len_r <= cfg_pwdata[scd_pkg::MLEN_W-1:0];
      geo_r     <= scd_pkg::cfg_from_len(cfg_pwdata[scd_pkg::MLEN_W-1:0]);
    end
  end

  // Register read-back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == scd_pkg::ADDR_MSG_LEN) begin
      cfg_prdata[scd_pkg::MLEN_W-1:0] = msg_len_r;
    end
  end

  // Datapath
  logic [scd_pkg::CODE_W-1:0] res_data;
  scd_pkg::status_t           res_status;
  logic [scd_pkg::SYN_W-1:0]  res_pos;
  logic [scd_pkg::CLEN_W-1:0] res_len;

  scd_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (geo_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser[0]),
    .in_data    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (res_data),
    .out_status (res_status),
    .out_pos    (res_pos),
    .out_len    (res_len)
  );

  assign out_tdata = {1'b0, res_len, res_pos, res_status, res_data};

endmodule

### tb/secded_codec_top_test.sv
// secded_codec_top_test: self-checking bench for the extended Hamming SECDED codec.
// Drives encode/decode requests and msg_len writes, predicts each result locally or takes it from the table.
// Depends on scd_pkg and secded_codec_top.
`timescale 1ns / 100ps

module secded_codec_top_test;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 200;

  // One codec result, split into its fields
  typedef struct packed {
    logic [scd_pkg::CODE_W-1:0] data;
    scd_pkg::status_t           st;
    logic [5:0]                 pos;
    logic [scd_pkg::CLEN_W-1:0] n;
  } codec_res_t;

  // Directed row: length setting, request, and typed-in result where it is obvious
  typedef struct packed {
    logic [scd_pkg::MLEN_W-1:0] len;
    logic                       cmd;
    logic [scd_pkg::CODE_W-1:0] data;
    logic                       known;
    logic [scd_pkg::CODE_W-1:0] x_data;
    scd_pkg::status_t           x_st;
    logic [5:0]                 x_pos;
    logic [scd_pkg::CLEN_W-1:0] x_n;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [22] = '{
    // reset length: all-zero and all-one words, ignored high message bits
    '{6'd57, scd_pkg::CMD_ENCODE, 64'h0, 1'b1, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd64},
    '{6'd57, scd_pkg::CMD_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
      scd_pkg::ST_OK, 6'd0, 7'd64},
    '{6'd57, scd_pkg::CMD_ENCODE, 64'hFE00_0000_0000_0000, 1'b1, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd64},
    '{6'd57, scd_pkg::CMD_ENCODE, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd0},
    '{6'd57, scd_pkg::CMD_DECODE, 64'h0, 1'b1, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd64},
    '{6'd57, scd_pkg::CMD_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h01FF_FFFF_FFFF_FFFF,
      scd_pkg::ST_OK, 6'd0, 7'd64},
    // single errors at a message bit and at the top position
    '{6'd57, scd_pkg::CMD_DECODE, 64'h20, 1'b1, 64'h0, scd_pkg::ST_SINGLE, 6'd5, 7'd64},
    '{6'd57, scd_pkg::CMD_DECODE, 64'h8000_0000_0000_0000, 1'b1, 64'h0,
      scd_pkg::ST_SINGLE, 6'd63, 7'd64},
    // zero syndrome with odd parity stays "no error"
    '{6'd57, scd_pkg::CMD_DECODE, 64'h1, 1'b1, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd64},
    // double error: flagged, message left uncorrected
    '{6'd57, scd_pkg::CMD_DECODE, 64'h28, 1'b1, 64'h3, scd_pkg::ST_DOUBLE, 6'd0, 7'd64},
    '{6'd57, scd_pkg::CMD_DECODE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd0},
    // length 0 acts as 1 (4-bit code), bits above the code ignored
    '{6'd0, scd_pkg::CMD_ENCODE, 64'h1, 1'b1, 64'hF, scd_pkg::ST_OK, 6'd0, 7'd4},
    '{6'd0, scd_pkg::CMD_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd4},
    '{6'd0, scd_pkg::CMD_DECODE, 64'hF, 1'b1, 64'h1, scd_pkg::ST_OK, 6'd0, 7'd4},
    '{6'd0, scd_pkg::CMD_DECODE, 64'hFFFF_FFFF_FFFF_FFF7, 1'b1, 64'h1,
      scd_pkg::ST_SINGLE, 6'd3, 7'd4},
    // syndrome pointing past a 10-bit code is uncorrectable
    '{6'd5, scd_pkg::CMD_DECODE, 64'h8000_0000_0000_0114, 1'b1, 64'h0,
      scd_pkg::ST_DOUBLE, 6'd0, 7'd10},
    '{6'd5, scd_pkg::CMD_ENCODE, 64'h1F, 1'b0, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd0},
    // lengths above the largest that fits act as 57
    '{6'd63, scd_pkg::CMD_ENCODE, 64'h0, 1'b1, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd64},
    '{6'd63, scd_pkg::CMD_DECODE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd0},
    '{6'd58, scd_pkg::CMD_DECODE, 64'h2, 1'b1, 64'h0, scd_pkg::ST_SINGLE, 6'd1, 7'd64},
    '{6'd26, scd_pkg::CMD_ENCODE, 64'h3FF_FFFF, 1'b0, 64'h0, scd_pkg::ST_OK, 6'd0, 7'd0},
    '{6'd26, scd_pkg::CMD_DECODE, 64'hFFFF_FFFF_0000_0001, 1'b0, 64'h0,
      scd_pkg::ST_OK, 6'd0, 7'd0}
  };

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [scd_pkg::CODE_W-1:0]  in_tdata;   // [63:0] data_in
  logic [0:0]                  in_tuser;   // [0] cmd
  logic                        out_tvalid;
  logic                        out_tready;
  logic [scd_pkg::OUT_W-1:0]   out_tdata;  // [63:0] data_out, [65:64] status,
                                           // [71:66] error_position, [78:72] code_length
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [scd_pkg::CFG_AW-1:0]  cfg_paddr;
  logic [scd_pkg::CFG_DW-1:0]  cfg_pwdata;
  logic [scd_pkg::CFG_DW-1:0]  cfg_prdata;
  logic                        cfg_pready;

  codec_res_t                  expected_words [$];
  logic [scd_pkg::MLEN_W-1:0]  msg_len_reg;   // local copy of the length register
  bit                          calm;          // last phase: no idling on either side
  int                          mismatches = 0;
  int                          idle_cycles = 0;

  secded_codec_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Code length for m message bits: m + p + 1, p least with 2^p - p >= m + 1
  function automatic int code_bits_for(input int m);
    int p;
    p = 1;
    while (((1 << p) - p) < m + 1) p++;
    return m + p + 1;
  endfunction

  // Written length as the codec uses it: 0 means 1, clamp to what fits
  function automatic int usable_len(input logic [scd_pkg::MLEN_W-1:0] raw);
    int m;
    m = int'(raw);
    if (m == 0) m = 1;
    while (m > 1 && code_bits_for(m) > scd_pkg::MAX_CODE_BITS) m--;
    return m;
  endfunction

  // Encode or check/correct/extract one word under length setting raw
  function automatic codec_res_t codec_predict(input logic cmd,
                                               input logic [scd_pkg::CODE_W-1:0] din,
                                               input logic [scd_pkg::MLEN_W-1:0] raw);
    codec_res_t                 r;
    logic [scd_pkg::CODE_W-1:0] cw;
    int                         m;
    int                         n;
    int                         k;
    int                         syn;
    logic                       par;
    m      = usable_len(raw);
    n      = code_bits_for(m);
    r.data = '0;
    r.st   = scd_pkg::ST_OK;
    r.pos  = '0;
    r.n    = scd_pkg::CLEN_W'(n);
    cw     = '0;
    k      = 0;
    syn    = 0;
    par    = 1'b0;
    if (cmd == scd_pkg::CMD_ENCODE) begin
      // message bits into non-power-of-two positions from 3 up
      for (int i = 1; i < n; i++) begin
        if (i >= 3 && (i & (i - 1)) != 0) begin
          cw[i] = din[k];
          k++;
        end
      end
      for (int i = 1; i < n; i++) begin
        if (cw[i]) syn ^= i;
      end
      for (int b = 1; b < n; b <<= 1) begin
        if ((syn & b) != 0) cw[b] = 1'b1;
      end
      cw[0]  = ^cw;
      r.data = cw;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (din[i]) begin
          syn ^= i;
          par = ~par;
        end
      end
      cw = din;
      if (syn != 0) begin
        if (!par || syn >= n) begin
          r.st = scd_pkg::ST_DOUBLE;
        end else begin
          r.st    = scd_pkg::ST_SINGLE;
          r.pos   = 6'(syn);
          cw[syn] = ~cw[syn];
        end
      end
      for (int i = 1; i < n; i++) begin
        if (i >= 3 && (i & (i - 1)) != 0) begin
          r.data[k] = cw[i];
          k++;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [scd_pkg::CODE_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Present one request and hold it until taken; returns at the accepting edge
  task automatic send_req(input logic cmd, input logic [scd_pkg::CODE_W-1:0] data,
                          input bit known, input codec_res_t typed);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (known) expected_words.push_back(typed);
    else expected_words.push_back(codec_predict(cmd, data, msg_len_reg));
  endtask

  task automatic pause(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= rand_word();
    repeat (cycles) @(posedge clk);
  endtask

  // Random sender gap between requests
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 7) == 0) pause($urandom_range(1, 10));
  endtask

  // Stop sending and let the pipeline empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // APB write of msg_len; upper data bits carry noise
  task automatic write_len(input logic [scd_pkg::MLEN_W-1:0] len);
    logic [scd_pkg::CFG_DW-1:0] wd;
    wd                      = $urandom();
    wd[scd_pkg::MLEN_W-1:0] = len;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= scd_pkg::ADDR_MSG_LEN;
    cfg_pwdata  <= wd;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    msg_len_reg = len;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver stalls in bursts, none in the last phase
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat (60) @(posedge clk);
        else repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Result check against the oldest expectation
  codec_res_t got_word;
  codec_res_t want_word;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.data = out_tdata[63:0];
      got_word.st   = scd_pkg::status_t'(out_tdata[65:64]);
      got_word.pos  = out_tdata[71:66];
      got_word.n    = out_tdata[78:72];
      if (expected_words.size() == 0) begin
        $display("%0t: result with none expected: tdata %h", $time, out_tdata);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.data !== want_word.data) begin
          $display("%0t: data_out expected %h got %h", $time, want_word.data, got_word.data);
          mismatches++;
        end
        if (got_word.st !== want_word.st) begin
          $display("%0t: status expected %0d got %0d", $time, want_word.st, got_word.st);
          mismatches++;
        end
        if (got_word.pos !== want_word.pos) begin
          $display("%0t: error_position expected %0d got %0d", $time, want_word.pos,
                   got_word.pos);
          mismatches++;
        end
        if (got_word.n !== want_word.n) begin
          $display("%0t: code_length expected %0d got %0d", $time, want_word.n, got_word.n);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    codec_res_t                 typed;
    codec_res_t                 enc;
    logic [scd_pkg::CODE_W-1:0] word;
    logic [scd_pkg::MLEN_W-1:0] next_len;
    int                         n;
    int                         nflip;
    int                         u;
    int                         bitpos;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    msg_len_reg = scd_pkg::MSG_LEN_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; rewrite the length only where the row asks for another
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].len != msg_len_reg) begin
        drain();
        write_len(DIR_ROWS[r].len);
      end
      typed.data = DIR_ROWS[r].x_data;
      typed.st   = DIR_ROWS[r].x_st;
      typed.pos  = DIR_ROWS[r].x_pos;
      typed.n    = DIR_ROWS[r].x_n;
      send_req(DIR_ROWS[r].cmd, DIR_ROWS[r].data, DIR_ROWS[r].known, typed);
      maybe_gap();
    end

    // Random phases, each under its own length setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       next_len = 6'd1;
        1:       next_len = 6'd63;
        2:       next_len = 6'd0;
        3:       next_len = 6'd57;
        4:       next_len = 6'd4;
        default: next_len = scd_pkg::MLEN_W'($urandom_range(0, 63));
      endcase
      drain();
      write_len(next_len);
      if (ph == N_PHASES - 1) calm = 1'b1;
      n = code_bits_for(usable_len(msg_len_reg));
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        u = $urandom_range(0, 9);
        if (u < 2) begin
          send_req(scd_pkg::CMD_ENCODE, rand_word(), 1'b0, typed);
        end else if (u < 8) begin
          // valid code word with 0..3 flipped bits, maybe noise above the code
          enc  = codec_predict(scd_pkg::CMD_ENCODE, rand_word(), msg_len_reg);
          word = enc.data;
          u    = $urandom_range(0, 9);
          nflip = (u < 3) ? 0 : (u < 6) ? 1 : (u < 9) ? 2 : 3;
          for (int f = 0; f < nflip; f++) begin
            bitpos       = $urandom_range(0, n - 1);
            word[bitpos] = ~word[bitpos];
          end
          if (n < scd_pkg::CODE_W && $urandom_range(0, 1) == 1)
            word |= rand_word() & ~((64'd1 << n) - 64'd1);
          send_req(scd_pkg::CMD_DECODE, word, 1'b0, typed);
        end else begin
          send_req(scd_pkg::CMD_DECODE, rand_word(), 1'b0, typed);
        end
        maybe_gap();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
